// ----- hdl/utf8_to_code_point_decoder_defines.svh -----
// Assertion macros used by the decoder's top-level file.
`ifndef UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH
`define UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH

`ifndef SYNTH
// Implication within the same cycle.
`define U8CPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder check failed");
// Implication checked in the following cycle.
`define U8CPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decoder check failed");
`else
`define U8CPD_ASSERT_SAME(label, clk, rst, ante, cons)
`define U8CPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/u8cpd_pkg.sv -----
package u8cpd_pkg;

   localparam int CP_W        = 21;
   localparam int BYTE_W      = 8;
   localparam int CSR_W       = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_W-1:0]  MAX_CHARS_RESET = 16'hFFFF;
   localparam logic [BYTE_W-1:0] ASCII_LAST      = 8'h7F;
   localparam logic [BYTE_W-1:0] TWO_BYTE_LAST   = 8'hDF;
   localparam logic [BYTE_W-1:0] THREE_BYTE_LAST = 8'hEF;

   // One entry per accepted byte that yields results: a character, a
   // terminator, or a character followed by a terminator.
   typedef struct packed {
      logic            has_char;
      logic            has_term;
      logic [CP_W-1:0] cp;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- hdl/u8cpd_front.sv -----
module u8cpd_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [u8cpd_pkg::BYTE_W-1:0]     byte_in,
   input  logic [u8cpd_pkg::CSR_W-1:0]      max_chars,
   output logic                             op_valid,
   output u8cpd_pkg::op_type                op
);

   localparam int CMP_W = (COUNT_BITS > u8cpd_pkg::CSR_W) ? COUNT_BITS : u8cpd_pkg::CSR_W;

   logic [1:0]                    bytes_left_ff, bytes_left_in;
   logic [u8cpd_pkg::CP_W-1:0]    acc_ff, acc_in;
   logic [COUNT_BITS-1:0]         chars_out_ff, chars_out_in;
   logic                          discarding_ff, discarding_in;

   logic                          is_nul;
   logic                          cnt_full;
   logic                          inc_full;
   logic [COUNT_BITS-1:0]         chars_inc;
   logic [u8cpd_pkg::CP_W-1:0]    cont_acc;
   logic [u8cpd_pkg::CP_W-1:0]    nul_acc;

   always_comb begin
      is_nul    = (byte_in == '0);
      chars_inc = (chars_out_ff == '1) ? chars_out_ff : chars_out_ff + 1'b1;
      cnt_full  = CMP_W'(chars_out_ff) >= CMP_W'(max_chars);
      inc_full  = CMP_W'(chars_inc) >= CMP_W'(max_chars);
      cont_acc  = {acc_ff[u8cpd_pkg::CP_W-7:0], byte_in[5:0]};

      // A NUL inside a sequence fills the missing continuation bits with zeros.
      case (bytes_left_ff)
         2'd1:    nul_acc = {acc_ff[u8cpd_pkg::CP_W-7:0], 6'b0};
         2'd2:    nul_acc = {acc_ff[u8cpd_pkg::CP_W-13:0], 12'b0};
         2'd3:    nul_acc = {acc_ff[u8cpd_pkg::CP_W-19:0], 18'b0};
         default: nul_acc = acc_ff;
      endcase
   end

   always_comb begin
      bytes_left_in = bytes_left_ff;
      acc_in        = acc_ff;
      chars_out_in  = chars_out_ff;
      discarding_in = discarding_ff;
      op_valid      = 1'b0;
      op            = '0;

      if (accept) begin
         if (discarding_ff) begin
            if (is_nul) begin
               bytes_left_in = '0;
               acc_in        = '0;
               chars_out_in  = '0;
               discarding_in = 1'b0;
            end
         end else if (bytes_left_ff != 2'd0) begin
            if (is_nul) begin
               op_valid      = 1'b1;
               op.has_char   = 1'b1;
               op.has_term   = 1'b1;
               op.cp         = nul_acc;
               bytes_left_in = '0;
               acc_in        = '0;
               chars_out_in  = '0;
               discarding_in = 1'b0;
            end else if (bytes_left_ff == 2'd1) begin
               op_valid      = 1'b1;
               op.has_char   = 1'b1;
               op.has_term   = inc_full;
               op.cp         = cont_acc;
               bytes_left_in = '0;
               acc_in        = '0;
               chars_out_in  = chars_inc;
               discarding_in = inc_full;
            end else begin
               bytes_left_in = bytes_left_ff - 2'd1;
               acc_in        = cont_acc;
            end
         end else begin
            if (is_nul) begin
               op_valid      = 1'b1;
               op.has_term   = 1'b1;
               bytes_left_in = '0;
               acc_in        = '0;
               chars_out_in  = '0;
               discarding_in = 1'b0;
            end else if (cnt_full) begin
               // Capacity already used up: the lead byte is dropped.
               op_valid      = 1'b1;
               op.has_term   = 1'b1;
               discarding_in = 1'b1;
            end else if (byte_in <= u8cpd_pkg::ASCII_LAST) begin
               op_valid      = 1'b1;
               op.has_char   = 1'b1;
               op.has_term   = inc_full;
               op.cp         = u8cpd_pkg::CP_W'(byte_in);
               chars_out_in  = chars_inc;
               discarding_in = inc_full;
            end else if (byte_in <= u8cpd_pkg::TWO_BYTE_LAST) begin
               acc_in        = u8cpd_pkg::CP_W'(byte_in[4:0]);
               bytes_left_in = 2'd1;
            end else if (byte_in <= u8cpd_pkg::THREE_BYTE_LAST) begin
               acc_in        = u8cpd_pkg::CP_W'(byte_in[3:0]);
               bytes_left_in = 2'd2;
            end else begin
               acc_in        = u8cpd_pkg::CP_W'(byte_in[2:0]);
               bytes_left_in = 2'd3;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         acc_ff        <= '0;
         chars_out_ff  <= '0;
         discarding_ff <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         acc_ff        <= acc_in;
         chars_out_ff  <= chars_out_in;
         discarding_ff <= discarding_in;
      end
   end

endmodule

// ----- hdl/u8cpd_queue.sv -----
module u8cpd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  u8cpd_pkg::op_type     wr_data,
   input  logic                  rd_en,
   output u8cpd_pkg::op_type     rd_data,
   output u8cpd_pkg::qstat_type  stat
);

   u8cpd_pkg::op_type               entry_ff [u8cpd_pkg::QUEUE_DEPTH];
   logic [u8cpd_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [u8cpd_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [u8cpd_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                            do_wr;
   logic                            do_rd;

   always_comb begin
      stat.full  = (count_ff == u8cpd_pkg::QCNT_W'(u8cpd_pkg::QUEUE_DEPTH));
      stat.empty = (count_ff == '0);
      do_wr      = wr_en && !stat.full;
      do_rd      = rd_en && !stat.empty;
      rd_data    = entry_ff[rd_ptr_ff];
      wr_ptr_in  = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hdl/u8cpd_back.sv -----
module u8cpd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  u8cpd_pkg::op_type             q_data,
   input  u8cpd_pkg::qstat_type          q_stat,
   output logic                          q_pop,
   input  logic                          pop,
   output logic                          empty,
   output logic [u8cpd_pkg::CP_W-1:0]    code_point,
   output logic                          end_of_string
);

   logic                          out_valid_ff, out_valid_in;
   logic                          pend_term_ff, pend_term_in;
   logic [u8cpd_pkg::CP_W-1:0]    out_cp_ff, out_cp_in;
   logic                          out_eos_ff, out_eos_in;
   logic                          advance;

   always_comb begin
      advance      = !out_valid_ff || pop;
      q_pop        = advance && !pend_term_ff && !q_stat.empty;
      out_valid_in = out_valid_ff;
      pend_term_in = pend_term_ff;
      out_cp_in    = out_cp_ff;
      out_eos_in   = out_eos_ff;

      if (advance) begin
         if (pend_term_ff) begin
            // Second beat of an entry that carries a character and a terminator.
            out_valid_in = 1'b1;
            out_cp_in    = '0;
            out_eos_in   = 1'b1;
            pend_term_in = 1'b0;
         end else if (!q_stat.empty) begin
            out_valid_in = 1'b1;
            if (q_data.has_char) begin
               out_cp_in    = q_data.cp;
               out_eos_in   = 1'b0;
               pend_term_in = q_data.has_term;
            end else begin
               out_cp_in    = '0;
               out_eos_in   = 1'b1;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_term_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_term_ff <= pend_term_in;
      end
   end

   always_ff @(posedge clock) begin
      out_cp_ff  <= out_cp_in;
      out_eos_ff <= out_eos_in;
   end

   assign empty         = !out_valid_ff;
   assign code_point    = out_cp_ff;
   assign end_of_string = out_eos_ff;

endmodule

// ----- hdl/utf8_to_code_point_decoder.sv -----
// Channel   Handshake     Payload
// req       push / full   req_byte_in[7:0]
// rsp       pop / empty   rsp_code_point[20:0], rsp_end_of_string
// csr       csr_wr_en     csr_wr_data[15:0] (max_chars)
//
// One byte is taken per clock while full is low; the byte decoder settles each
// byte in the cycle it is accepted.
// The output register gives one result beat per clock while pop is high; a byte that
// ends a character and the string costs two output beats.
// A result passes through the queue and then the output register on its way to rsp.
// A four-entry queue between decoder and output lets either side stall alone.
// Reset is synchronous and leaves max_chars at 65535 with the queue empty.
`include "utf8_to_code_point_decoder_defines.svh"

module utf8_to_code_point_decoder #(
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [u8cpd_pkg::BYTE_W-1:0]      req_byte_in,
   output logic                              empty,
   input  logic                              pop,
   output logic [u8cpd_pkg::CP_W-1:0]        rsp_code_point,
   output logic                              rsp_end_of_string,
   input  logic                              csr_wr_en,
   input  logic [u8cpd_pkg::CSR_W-1:0]       csr_wr_data
);

   logic [u8cpd_pkg::CSR_W-1:0]  max_chars_ff;
   logic                         accept;
   logic                         op_valid;
   u8cpd_pkg::op_type            op;
   u8cpd_pkg::op_type            q_data;
   u8cpd_pkg::qstat_type         q_stat;
   logic                         q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= u8cpd_pkg::MAX_CHARS_RESET;
      end else if (csr_wr_en) begin
         max_chars_ff <= csr_wr_data;
      end
   end

   assign full   = q_stat.full;
   assign accept = push && !q_stat.full;

   u8cpd_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .byte_in   (req_byte_in),
      .max_chars (max_chars_ff),
      .op_valid  (op_valid),
      .op        (op)
   );

   u8cpd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (op_valid),
      .wr_data (op),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .stat    (q_stat)
   );

   u8cpd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_data        (q_data),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .pop           (pop),
      .empty         (empty),
      .code_point    (rsp_code_point),
      .end_of_string (rsp_end_of_string)
   );

   `U8CPD_ASSERT_SAME(a_term_has_zero_cp, clock, reset, !empty && rsp_end_of_string, rsp_code_point == '0)
   `U8CPD_ASSERT_NEXT(a_reset_clears_output, clock, 1'b0, reset, empty && !full)
   `U8CPD_ASSERT_SAME(a_full_queue_means_output_held, clock, reset, q_stat.full, !empty)

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

   localparam int CP_W   = u8cpd_pkg::CP_W;
   localparam int BYTE_W = u8cpd_pkg::BYTE_W;
   localparam int CSR_W  = u8cpd_pkg::CSR_W;

   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [CP_W-1:0] cp;
      logic            eos;
   } code_point_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic [BYTE_W-1:0] req_byte_in = '0;
   logic              empty;
   logic              pop = 1'b0;
   logic [CP_W-1:0]   rsp_code_point;
   logic              rsp_end_of_string;
   logic              csr_wr_en = 1'b0;
   logic [CSR_W-1:0]  csr_wr_data = '0;

   // Bytes waiting to be offered, and code points the decoder still owes us.
   logic [BYTE_W-1:0]   bytes_to_send[$];
   code_point_beat_type code_points_due[$];

   int  bytes_queued = 0;
   int  bytes_accepted = 0;
   int  rsp_beats = 0;
   int  error_count = 0;
   bit  byte_taken = 1'b0;
   bit  idle_en = 1'b1;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  hold_cnt = 0;
   bit  long_hold_done = 1'b0;

   // Decoder state as the predictor sees it.
   logic [1:0]       dec_bytes_left = '0;
   logic [CP_W-1:0]  dec_acc = '0;
   logic [15:0]      dec_chars = '0;
   bit               dec_discard = 1'b0;
   logic [CSR_W-1:0] cap_max = u8cpd_pkg::MAX_CHARS_RESET;

   utf8_to_code_point_decoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_byte_in       (req_byte_in),
      .empty             (empty),
      .pop               (pop),
      .rsp_code_point    (rsp_code_point),
      .rsp_end_of_string (rsp_end_of_string),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      else if (r < 95) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   task automatic owe(input logic [CP_W-1:0] cp, input logic eos);
      code_point_beat_type beat;
      beat.cp = cp;
      beat.eos = eos;
      code_points_due.push_back(beat);
   endtask

   task automatic start_string();
      dec_bytes_left = '0;
      dec_acc = '0;
      dec_chars = '0;
      dec_discard = 1'b0;
   endtask

   task automatic complete_char(input logic [CP_W-1:0] cp, input bit at_nul);
      owe(cp, 1'b0);
      if (dec_chars != '1) dec_chars = dec_chars + 1'b1;
      dec_bytes_left = '0;
      dec_acc = '0;
      if (at_nul) begin
         owe('0, 1'b1);
         start_string();
      end else if (dec_chars >= cap_max) begin
         owe('0, 1'b1);
         dec_discard = 1'b1;
      end
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      logic [CP_W-1:0] cp;
      if (dec_discard) begin
         if (b == '0) start_string();
      end else if (dec_bytes_left != 0) begin
         if (b == '0) begin
            // The missing continuation bytes count as zero bits.
            cp = dec_acc << (6 * dec_bytes_left);
            complete_char(cp, 1'b1);
         end else begin
            dec_acc = {dec_acc[CP_W-7:0], b[5:0]};
            dec_bytes_left = dec_bytes_left - 1'b1;
            if (dec_bytes_left == 0) complete_char(dec_acc, 1'b0);
         end
      end else if (b == '0) begin
         owe('0, 1'b1);
         start_string();
      end else if (dec_chars >= cap_max) begin
         owe('0, 1'b1);
         dec_discard = 1'b1;
      end else if (b <= u8cpd_pkg::ASCII_LAST) begin
         complete_char(CP_W'(b), 1'b0);
      end else if (b <= u8cpd_pkg::TWO_BYTE_LAST) begin
         dec_acc = CP_W'(b[4:0]);
         dec_bytes_left = 2'd1;
      end else if (b <= u8cpd_pkg::THREE_BYTE_LAST) begin
         dec_acc = CP_W'(b[3:0]);
         dec_bytes_left = 2'd2;
      end else begin
         dec_acc = CP_W'(b[2:0]);
         dec_bytes_left = 2'd3;
      end
   endtask

   // Check result beats, follow register writes and predict from accepted bytes.
   always @(posedge clock) begin
      code_point_beat_type exp_beat;
      if (!reset) begin
         if (pop && !empty) begin
            rsp_beats++;
            if (code_points_due.size() == 0) begin
               $error("unexpected beat: code_point %h end_of_string %b",
                      rsp_code_point, rsp_end_of_string);
               error_count++;
            end else begin
               exp_beat = code_points_due.pop_front();
               if (rsp_code_point !== exp_beat.cp) begin
                  $error("code_point: expected %h, got %h", exp_beat.cp, rsp_code_point);
                  error_count++;
               end
               if (rsp_end_of_string !== exp_beat.eos) begin
                  $error("end_of_string: expected %b, got %b",
                         exp_beat.eos, rsp_end_of_string);
                  error_count++;
               end
            end
         end
         if (csr_wr_en) cap_max = csr_wr_data;
         byte_taken = push && !full;
         if (byte_taken) begin
            decode_byte(req_byte_in);
            bytes_accepted++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || byte_taken) begin
         if (req_gap != 0) begin
            req_gap--;
            push <= 1'b0;
         end else if (bytes_to_send.size() != 0) begin
            req_byte_in <= bytes_to_send.pop_front();
            push <= 1'b1;
            req_gap = idle_en ? draw_gap() : 0;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // The receiver stalls once for a long stretch so that the decoder backs up.
   // It waits for a good stock of bytes so that the sender keeps offering.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt--;
         pop <= 1'b0;
      end else if (!long_hold_done && rsp_beats >= 100 && bytes_to_send.size() >= 60) begin
         long_hold_done = 1'b1;
         hold_cnt = 200;
         pop <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap--;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
         rsp_gap = idle_en ? draw_gap() : 0;
      end
   end

   task automatic queue_byte(input logic [BYTE_W-1:0] b);
      bytes_to_send.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_bytes(input logic [BYTE_W-1:0] seq[]);
      foreach (seq[i]) queue_byte(seq[i]);
   endtask

   function automatic logic [BYTE_W-1:0] draw_cont();
      if ($urandom_range(0, 3) == 0) return BYTE_W'($urandom_range(1, 255));
      return {2'b10, 6'($urandom_range(0, 63))};
   endfunction

   // Mostly well-formed characters, with some noise bytes and the odd early NUL.
   task automatic queue_string(input int n_chars);
      int len;
      int j;
      for (int i = 0; i < n_chars; i++) begin
         if ($urandom_range(0, 99) < 8) begin
            queue_byte(BYTE_W'($urandom_range(0, 255)));
         end else begin
            len = $urandom_range(1, 4);
            case (len)
               1: queue_byte(BYTE_W'($urandom_range(1, 127)));
               2: queue_byte(BYTE_W'($urandom_range(8'h80, 8'hDF)));
               3: queue_byte(BYTE_W'($urandom_range(8'hE0, 8'hEF)));
               default: queue_byte(BYTE_W'($urandom_range(8'hF0, 8'hFF)));
            endcase
            j = 1;
            while (j < len) begin
               if ($urandom_range(0, 29) == 0) begin
                  queue_byte('0);
                  j = len;
               end else begin
                  queue_byte(draw_cont());
                  j++;
               end
            end
         end
      end
      queue_byte('0);
   endtask

   // Every byte taken and every code point delivered, then room for stragglers.
   task automatic wait_idle();
      while (bytes_to_send.size() != 0 || bytes_accepted != bytes_queued ||
             code_points_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_chars(input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [CSR_W-1:0] caps[7];
      int phase_start;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Range boundaries of each lead byte, full and empty payloads, NUL cases.
      queue_bytes('{8'h41, 8'h7F, 8'h01, 8'hC2, 8'hA9, 8'h80, 8'hFF, 8'hDF, 8'hBF,
                    8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h9F, 8'h98,
                    8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00});
      queue_bytes('{8'hE2, 8'h82, 8'h00, 8'hF4, 8'h00});
      wait_idle();

      // No capacity at all: the first lead byte forces the terminator.
      write_max_chars(16'h0000);
      queue_bytes('{8'h41, 8'h42, 8'h00, 8'h00});
      wait_idle();

      // Capacity reached by an ASCII character and by a multi-byte one.
      write_max_chars(16'h0002);
      queue_bytes('{8'h61, 8'h62, 8'h63, 8'hC3, 8'hA9, 8'h00,
                    8'h61, 8'hC3, 8'hA9, 8'hF0, 8'h90, 8'h00});
      wait_idle();

      // Capacity lowered below the count already given within a string.
      write_max_chars(16'hFFFF);
      queue_bytes('{8'h61, 8'h62, 8'h63, 8'h64});
      wait_idle();
      write_max_chars(16'h0002);
      queue_bytes('{8'h65, 8'h66, 8'h00});
      wait_idle();

      caps = '{16'd1, 16'd3, 16'hFFFF, CSR_W'($urandom_range(4, 30)),
               CSR_W'($urandom_range(0, 65535)), 16'd2, 16'd0};
      foreach (caps[p]) begin
         write_max_chars(caps[p]);
         idle_en = (p != 3);
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < ((caps[p] == 0) ? 40 : 190))
            queue_string($urandom_range(0, 12));
         wait_idle();
      end

      if (error_count == 0 && code_points_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/u8cpd_pkg.sv
hdl/u8cpd_front.sv
hdl/u8cpd_queue.sv
hdl/u8cpd_back.sv
hdl/utf8_to_code_point_decoder.sv
sim/testbench.sv
